// File: design/cter_pkg.sv
// ----------------------------------------------------------------------------
// cter_pkg
// Shared types and constants of the cross-thread edge recorder: field widths,
// result status codes, the edge table entry and the sequencer states.
// ----------------------------------------------------------------------------
package cter_pkg;

   localparam int WATCH_W  = 2;
   localparam int PC_W     = 48;
   localparam int THREAD_W = 16;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = 8;

   // result status codes
   localparam logic [STATUS_W-1:0] EDGE_SAME    = 2'd0;
   localparam logic [STATUS_W-1:0] EDGE_PRESENT = 2'd1;
   localparam logic [STATUS_W-1:0] EDGE_STORED  = 2'd2;
   localparam logic [STATUS_W-1:0] EDGE_FULL    = 2'd3;

   typedef struct packed {
      logic [PC_W-1:0] source_pc;
      logic [PC_W-1:0] sink_pc;
   } edge_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } tbl_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

endpackage

// File: design/cter_if.sv
// ----------------------------------------------------------------------------
// cter_if
// Valid/ready channels of the edge recorder: watchpoint hit requests and
// edge classification responses.
// ----------------------------------------------------------------------------
interface cter_req_if;
   logic                           valid;
   logic                           ready;
   logic [cter_pkg::WATCH_W-1:0]   watch_index;
   logic [cter_pkg::PC_W-1:0]      access_pc;
   logic [cter_pkg::THREAD_W-1:0]  thread_id;

   modport source (output valid, watch_index, access_pc, thread_id, input ready);
   modport sink   (input valid, watch_index, access_pc, thread_id, output ready);
endinterface

interface cter_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [cter_pkg::STATUS_W-1:0]  edge_status;
   logic [cter_pkg::SLOT_W-1:0]    edge_slot;
   logic [cter_pkg::PC_W-1:0]      source_pc;

   modport source (output valid, edge_status, edge_slot, source_pc, input ready);
   modport sink   (input valid, edge_status, edge_slot, source_pc, output ready);
endinterface

// File: design/cter_edge_table.sv
// ----------------------------------------------------------------------------
// cter_edge_table
// Edge table storage: one write port, one registered read port, and the
// comparator that matches the read entry against the searched edge.
// ----------------------------------------------------------------------------
module cter_edge_table #(
   parameter int TABLE_ENTRIES = 256
) (
   input  logic                                 clock,
   input  cter_pkg::tbl_ctl_type                ctl,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]     rd_addr,
   input  logic [$clog2(TABLE_ENTRIES)-1:0]     wr_addr,
   input  cter_pkg::edge_type                   wr_data,
   input  cter_pkg::edge_type                   key,
   output logic                                 hit
);

   cter_pkg::edge_type mem [TABLE_ENTRIES];
   cter_pkg::edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign hit = (rd_data_ff == key);

endmodule

// File: design/cross_thread_edge_recorder_core.sv
// ----------------------------------------------------------------------------
// cross_thread_edge_recorder_core
// Keeps a last-writer record per watchpoint and records cross-thread
// communication edges in a table searched one slot per cycle.
// ----------------------------------------------------------------------------
//  channel    direction  handshake      payload
//  req_chan   in         valid/ready    watch_index, access_pc, thread_id
//  rsp_chan   out        valid/ready    edge_status, edge_slot, source_pc
//
//  A same-thread hit goes from the record check straight to the result; a
//  cross-thread hit searches up to TABLE_ENTRIES slots of the edge table,
//  one per cycle, through its single read port in slot order.
//  Reset clears the records and the fill count; table slots at or above the
//  fill count are never read, so the table needs no clearing pass.
//  req_chan is ready only while idle; a stalled result waits in the output
//  register and the next request may be taken meanwhile.
// ----------------------------------------------------------------------------
module cross_thread_edge_recorder_core #(
   parameter int TABLE_ENTRIES = 256,
   parameter int WATCHPOINTS   = 4
) (
   input  logic         clock,
   input  logic         reset,
   cter_req_if.sink     req_chan,
   cter_rsp_if.source   rsp_chan
);

   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W    = $clog2(TABLE_ENTRIES + 1);
   localparam int WP_IDX_W = (WATCHPOINTS > 1) ? $clog2(WATCHPOINTS) : 1;

   cter_pkg::state_type               state_ff, state_in;
   logic [WP_IDX_W-1:0]               wp_ff, wp_in;
   logic                              wp_ok_ff, wp_ok_in;
   logic [cter_pkg::PC_W-1:0]         pc_ff, pc_in;
   logic [cter_pkg::THREAD_W-1:0]     thd_ff, thd_in;
   logic [cter_pkg::PC_W-1:0]         src_ff, src_in;
   logic [CNT_W-1:0]                  rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]                  cmp_idx_ff, cmp_idx_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic [cter_pkg::STATUS_W-1:0]     res_status_ff, res_status_in;
   logic [cter_pkg::SLOT_W-1:0]       res_slot_ff, res_slot_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [cter_pkg::STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [cter_pkg::SLOT_W-1:0]       rsp_slot_ff, rsp_slot_in;
   logic [cter_pkg::PC_W-1:0]         rsp_src_ff, rsp_src_in;

   logic [cter_pkg::PC_W-1:0]         last_pc_ff  [WATCHPOINTS];
   logic [cter_pkg::THREAD_W-1:0]     last_thd_ff [WATCHPOINTS];
   logic [cter_pkg::PC_W-1:0]         rec_pc;
   logic [cter_pkg::THREAD_W-1:0]     rec_thd;
   logic                              rec_wr_pc;
   logic                              rec_wr_thd;

   cter_pkg::tbl_ctl_type             tbl_ctl;
   logic [IDX_W-1:0]                  tbl_rd_addr;
   cter_pkg::edge_type                tbl_wr_data;
   cter_pkg::edge_type                tbl_key;
   logic                              tbl_hit;
   logic                              last_slot;

   cter_edge_table #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .rd_addr (tbl_rd_addr),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (tbl_wr_data),
      .key     (tbl_key),
      .hit     (tbl_hit)
   );

   assign rec_pc   = last_pc_ff[wp_ff];
   assign rec_thd  = last_thd_ff[wp_ff];
   assign tbl_key  = '{source_pc: src_ff, sink_pc: pc_ff};
   assign last_slot = ((CNT_W'(cmp_idx_ff) + CNT_W'(1)) == count_ff);

   assign req_chan.ready       = (state_ff == cter_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.edge_status = rsp_status_ff;
   assign rsp_chan.edge_slot   = rsp_slot_ff;
   assign rsp_chan.source_pc   = rsp_src_ff;

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      wp_ok_in      = wp_ok_ff;
      pc_in         = pc_ff;
      thd_in        = thd_ff;
      src_in        = src_ff;
      rd_idx_in     = rd_idx_ff;
      cmp_idx_in    = cmp_idx_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_src_in    = rsp_src_ff;
      rec_wr_pc     = 1'b0;
      rec_wr_thd    = 1'b0;
      tbl_ctl       = '{rd_en: 1'b0, wr_en: 1'b0};
      tbl_rd_addr   = rd_idx_ff[IDX_W-1:0];
      tbl_wr_data   = '{source_pc: src_ff, sink_pc: pc_ff};

      unique case (state_ff)
         cter_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               wp_in    = WP_IDX_W'(req_chan.watch_index);
               wp_ok_in = (32'(req_chan.watch_index) < 32'(WATCHPOINTS));
               pc_in    = req_chan.access_pc;
               thd_in   = req_chan.thread_id;
               state_in = cter_pkg::ST_CHECK;
            end
         end
         cter_pkg::ST_CHECK: begin
            res_slot_in = '0;
            cmp_idx_in  = '0;
            if (!wp_ok_ff) begin
               // unknown watchpoint: no state change, all-zero result
               src_in        = '0;
               res_status_in = cter_pkg::EDGE_SAME;
               state_in      = cter_pkg::ST_DONE;
            end else begin
               src_in    = rec_pc;
               rec_wr_pc = 1'b1;
               if (rec_thd == thd_ff) begin
                  res_status_in = cter_pkg::EDGE_SAME;
                  state_in      = cter_pkg::ST_DONE;
               end else if (count_ff == '0) begin
                  tbl_ctl.wr_en = 1'b1;
                  tbl_wr_data   = '{source_pc: rec_pc, sink_pc: pc_ff};
                  count_in      = count_ff + CNT_W'(1);
                  rec_wr_thd    = 1'b1;
                  res_status_in = cter_pkg::EDGE_STORED;
                  state_in      = cter_pkg::ST_DONE;
               end else begin
                  // first slot read goes out now, compared next cycle
                  tbl_ctl.rd_en = 1'b1;
                  tbl_rd_addr   = '0;
                  rd_idx_in     = CNT_W'(1);
                  state_in      = cter_pkg::ST_SCAN;
               end
            end
         end
         cter_pkg::ST_SCAN: begin
            tbl_ctl.rd_en = (rd_idx_ff < count_ff);
            if (tbl_ctl.rd_en) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end
            cmp_idx_in = rd_idx_ff[IDX_W-1:0];
            if (tbl_hit) begin
               rec_wr_thd    = 1'b1;
               res_status_in = cter_pkg::EDGE_PRESENT;
               res_slot_in   = cter_pkg::SLOT_W'(cmp_idx_ff);
               state_in      = cter_pkg::ST_DONE;
            end else if (last_slot) begin
               if (count_ff == CNT_W'(TABLE_ENTRIES)) begin
                  res_status_in = cter_pkg::EDGE_FULL;
                  res_slot_in   = '0;
               end else begin
                  tbl_ctl.wr_en = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
                  rec_wr_thd    = 1'b1;
                  res_status_in = cter_pkg::EDGE_STORED;
                  res_slot_in   = cter_pkg::SLOT_W'(count_ff);
               end
               state_in = cter_pkg::ST_DONE;
            end
         end
         cter_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_src_in    = src_ff;
               state_in      = cter_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cter_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cter_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wp_ff         <= wp_in;
      wp_ok_ff      <= wp_ok_in;
      pc_ff         <= pc_in;
      thd_ff        <= thd_in;
      src_ff        <= src_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_src_ff    <= rsp_src_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WATCHPOINTS; i++) begin
            last_pc_ff[i]  <= '0;
            last_thd_ff[i] <= '0;
         end
      end else begin
         if (rec_wr_pc) begin
            last_pc_ff[wp_ff] <= pc_ff;
         end
         if (rec_wr_thd) begin
            last_thd_ff[wp_ff] <= thd_ff;
         end
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_ENTRIES))
      else $error("edge table fill count above table size");

   a_write_counts: assert property (@(posedge clock) disable iff (reset)
      tbl_ctl.wr_en |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("edge table write without fill count advance");

   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == cter_pkg::ST_SCAN |-> count_ff != '0)
      else $error("table scan started on an empty table");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == cter_pkg::EDGE_SAME ||
                       rsp_status_ff == cter_pkg::EDGE_FULL) |-> rsp_slot_ff == '0)
      else $error("nonzero slot on same-thread or dropped result");

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> state_ff == cter_pkg::ST_CHECK)
      else $error("accepted request not taken to record check");

endmodule

// File: bench/cter_edge_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cter_edge_checker
// Watches the hit and result channels of the edge recorder, keeps its own
// copy of the last-writer records and the edge table, predicts the
// classification of every accepted hit and compares it with the results
// in order. Hands the mismatch count and the number of pending hits to the
// test top.
// ----------------------------------------------------------------------------
module cter_edge_checker #(
   parameter int TABLE_SLOTS = 256,
   parameter int WATCH_COUNT = 4
) (
   input  logic  clock,
   input  logic  reset,
   cter_req_if   hit_mon,
   cter_rsp_if   verdict_mon,
   output int    mismatch_count,
   output int    pending_hits
);

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [cter_pkg::STATUS_W-1:0] status;
      logic [cter_pkg::SLOT_W-1:0]   slot;
      logic [cter_pkg::PC_W-1:0]     source_pc;
   } edge_verdict_type;

   logic [cter_pkg::PC_W-1:0]     writer_pc     [WATCH_COUNT];
   logic [cter_pkg::THREAD_W-1:0] writer_thread [WATCH_COUNT];
   logic [cter_pkg::PC_W-1:0]     table_source  [TABLE_SLOTS];
   logic [cter_pkg::PC_W-1:0]     table_sink    [TABLE_SLOTS];
   int                            table_fill;
   edge_verdict_type              expected_verdicts[$];

   // only slots below table_fill are searched, so contents above it mean nothing
   task automatic classify_hit(input logic [cter_pkg::WATCH_W-1:0] w,
                               input logic [cter_pkg::PC_W-1:0] pc,
                               input logic [cter_pkg::THREAD_W-1:0] thr,
                               output edge_verdict_type v);
      int  idx;
      bit  found;
      v     = '0;
      found = 1'b0;
      if (int'(w) >= WATCH_COUNT) return;
      v.source_pc = writer_pc[w];
      if (writer_thread[w] != thr) begin
         v.status = cter_pkg::EDGE_FULL;
         for (idx = 0; idx < table_fill && !found; idx++) begin
            if (table_source[idx] == v.source_pc && table_sink[idx] == pc) begin
               found    = 1'b1;
               v.status = cter_pkg::EDGE_PRESENT;
               v.slot   = cter_pkg::SLOT_W'(idx);
            end
         end
         if (!found && table_fill < TABLE_SLOTS) begin
            table_source[table_fill] = v.source_pc;
            table_sink[table_fill]   = pc;
            v.status = cter_pkg::EDGE_STORED;
            v.slot   = cter_pkg::SLOT_W'(table_fill);
            table_fill++;
         end
         if (v.status != cter_pkg::EDGE_FULL) writer_thread[w] = thr;
      end
      writer_pc[w] = pc;
   endtask

   task automatic flag_mismatch(input string what, input logic [cter_pkg::PC_W-1:0] want,
                                input logic [cter_pkg::PC_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t: edge result mismatch on %s: expected %h, got %h",
                  $time, what, want, got);
   endtask

   always @(posedge clock) begin
      edge_verdict_type want;
      edge_verdict_type got;
      if (reset) begin
         for (int i = 0; i < WATCH_COUNT; i++) begin
            writer_pc[i]     = '0;
            writer_thread[i] = '0;
         end
         table_fill = 0;
         mismatch_count = 0;
         expected_verdicts.delete();
      end else begin
         if (verdict_mon.valid && verdict_mon.ready) begin
            got.status    = verdict_mon.edge_status;
            got.slot      = verdict_mon.edge_slot;
            got.source_pc = verdict_mon.source_pc;
            if (expected_verdicts.size() == 0) begin
               flag_mismatch("result with no hit pending, source_pc", '0, got.source_pc);
            end else begin
               want = expected_verdicts.pop_front();
               if (got.status !== want.status)
                  flag_mismatch("edge_status", cter_pkg::PC_W'(want.status),
                                cter_pkg::PC_W'(got.status));
               if (got.slot !== want.slot)
                  flag_mismatch("edge_slot", cter_pkg::PC_W'(want.slot),
                                cter_pkg::PC_W'(got.slot));
               if (got.source_pc !== want.source_pc)
                  flag_mismatch("source_pc", want.source_pc, got.source_pc);
            end
         end
         if (hit_mon.valid && hit_mon.ready) begin
            classify_hit(hit_mon.watch_index, hit_mon.access_pc, hit_mon.thread_id, want);
            expected_verdicts.push_back(want);
         end
      end
      pending_hits = expected_verdicts.size();
   end

endmodule

// File: bench/cross_thread_edge_recorder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cross_thread_edge_recorder_core_test
// Drives watchpoint hits into the edge recorder: a directed opening with
// zero and all-ones addresses and threads, then random hits drawn mostly
// from a small address pool so that edges repeat and the table fills up
// and overflows. Both channels idle at random in the first two phases; the result
// side also holds off for a long stretch once. The checker beside the
// block predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module cross_thread_edge_recorder_core_test;

   localparam int TABLE_SLOTS   = 256;
   localparam int WATCH_COUNT   = 4;
   localparam int PHASE_HITS    = 400;
   localparam int PC_POOL_SIZE  = 24;
   localparam int THREAD_POOL   = 4;
   localparam int LONG_HOLD     = 600;
   localparam int DRAIN_CYCLES  = 300;
   localparam int CYCLE_LIMIT   = 3_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit long_hold_req = 1'b0;
   int mismatch_count;
   int pending_hits;
   int cycle_count = 0;

   logic [cter_pkg::PC_W-1:0]     pc_pool     [PC_POOL_SIZE];
   logic [cter_pkg::THREAD_W-1:0] thread_pool [THREAD_POOL];

   cter_req_if hit_chan();
   cter_rsp_if verdict_chan();

   cross_thread_edge_recorder_core #(
      .TABLE_ENTRIES (TABLE_SLOTS),
      .WATCHPOINTS   (WATCH_COUNT)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (hit_chan),
      .rsp_chan (verdict_chan)
   );

   cter_edge_checker #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .WATCH_COUNT (WATCH_COUNT)
   ) u_edge_check (
      .clock          (clock),
      .reset          (reset),
      .hit_mon        (hit_chan),
      .verdict_mon    (verdict_chan),
      .mismatch_count (mismatch_count),
      .pending_hits   (pending_hits)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stalls, plus one long hold-off counted here
   initial begin
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      verdict_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_taken) begin
            hold_left  = LONG_HOLD;
            hold_taken = 1'b1;
         end
         if (reset) begin
            verdict_chan.ready <= 1'b0;
         end else if (hold_left > 0) begin
            verdict_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            verdict_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cross_thread_edge_recorder_core_test: FAIL");
      $finish;
   end

   // returns at the rising edge of the transfer; valid stays up for the next call
   task automatic send_hit(input logic [cter_pkg::WATCH_W-1:0] w,
                           input logic [cter_pkg::PC_W-1:0] pc,
                           input logic [cter_pkg::THREAD_W-1:0] thr);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         hit_chan.valid <= 1'b0;
         @(negedge clock);
      end
      hit_chan.valid       <= 1'b1;
      hit_chan.watch_index <= w;
      hit_chan.access_pc   <= pc;
      hit_chan.thread_id   <= thr;
      @(posedge clock);
      while (!hit_chan.ready) @(posedge clock);
   endtask

   task automatic quiet_sender();
      @(negedge clock);
      hit_chan.valid <= 1'b0;
   endtask

   // mostly pooled addresses and threads so edges repeat; some fully random noise
   task automatic random_hit();
      logic [cter_pkg::PC_W-1:0]     pc;
      logic [cter_pkg::THREAD_W-1:0] thr;
      if ($urandom_range(99) < 10) begin
         pc  = {16'($urandom), $urandom};
         thr = 16'($urandom_range(65535, 1));
      end else begin
         pc  = pc_pool[$urandom_range(PC_POOL_SIZE - 1)];
         thr = thread_pool[$urandom_range(THREAD_POOL - 1)];
      end
      send_hit(cter_pkg::WATCH_W'($urandom_range(WATCH_COUNT - 1)), pc, thr);
   endtask

   initial begin
      hit_chan.valid       = 1'b0;
      hit_chan.watch_index = '0;
      hit_chan.access_pc   = '0;
      hit_chan.thread_id   = '0;

      pc_pool[0] = '0;
      pc_pool[1] = '1;
      for (int i = 2; i < PC_POOL_SIZE; i++) pc_pool[i] = {16'($urandom), $urandom};
      thread_pool[0] = 16'd1;
      thread_pool[1] = 16'd2;
      thread_pool[2] = 16'd3;
      thread_pool[3] = 16'($urandom_range(65535, 4));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      recv_idle_pct = 58;

      // thread zero right after reset matches the cleared record
      send_hit(2'd0, '0, 16'h0000);
      // edge between two zero addresses is a real edge
      send_hit(2'd0, '0, 16'h0001);
      send_hit(2'd1, '0, 16'h0001);
      send_hit(2'd1, '1, 16'hFFFF);
      send_hit(2'd1, '1, 16'hFFFF);
      send_hit(2'd2, 48'h5555_5555_5555, 16'h5555);
      send_hit(2'd2, 48'hAAAA_AAAA_AAAA, 16'hAAAA);
      send_hit(2'd3, 48'h8000_0000_0000, 16'h8000);
      send_hit(2'd3, 48'h0000_0000_0001, 16'h0001);
      send_hit(2'd3, 48'h8000_0000_0000, 16'h8000);
      send_hit(2'd2, 48'h8000_0000_0000, 16'h7FFF);
      send_hit(2'd0, '1, 16'hFFFE);
      send_hit(2'd0, '0, 16'h0001);
      send_hit(2'd3, 48'h0000_0000_0001, 16'h0001);
      send_hit(2'd3, 48'h8000_0000_0000, 16'h8000);

      for (int i = 0; i < PHASE_HITS; i++) begin
         if (i == 100) long_hold_req = 1'b1;
         random_hit();
      end
      quiet_sender();
      wait (pending_hits == 0);

      send_idle_pct = 58;
      recv_idle_pct = 20;
      for (int i = 0; i < PHASE_HITS; i++) random_hit();
      quiet_sender();
      wait (pending_hits == 0);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < PHASE_HITS; i++) random_hit();
      quiet_sender();
      wait (pending_hits == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_hits == 0) begin
         $display("cross_thread_edge_recorder_core_test: PASS");
      end else begin
         $display("cross_thread_edge_recorder_core_test: FAIL");
      end
      $finish;
   end

endmodule

// File: sim.f
design/cter_pkg.sv
design/cter_if.sv
design/cter_edge_table.sv
design/cross_thread_edge_recorder_core.sv
bench/cter_edge_checker.sv
bench/cross_thread_edge_recorder_core_test.sv
